[rtl/conveyor_zone_station_sequencer_macros.svh]
// assertion macros for the conveyor zone station sequencer checker
// used by czss_checker; no other dependencies
`ifndef CONVEYOR_ZONE_STATION_SEQUENCER_MACROS_SVH
`define CONVEYOR_ZONE_STATION_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CZSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("czss check failed");

// next-cycle implication, disabled while reset is asserted
`define CZSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("czss check failed");

`endif

[rtl/czss_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the conveyor zone station sequencer
// no dependencies
package czss_pkg;

  localparam int unsigned PinW   = 8;
  localparam int unsigned DwellW = 8;
  localparam int unsigned LevelW = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  localparam logic [LevelW-1:0] RunLevel = 12'd4095;

  typedef enum logic [2:0] {
    PH_RESET       = 3'd0,
    PH_WAIT_ENTER  = 3'd1,
    PH_WAIT_HOLD   = 3'd2,
    PH_OPERATION   = 3'd3,
    PH_WAIT_NEXT   = 3'd4,
    PH_WAIT_EXIT   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    STEP_BEFORE = 2'd0,
    STEP_MIDDLE = 2'd1,
    STEP_AFTER  = 2'd2
  } step_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTER_PIN    = 3'd0,
    REG_HOLD_PIN     = 3'd1,
    REG_EXIT_PIN     = 3'd2,
    REG_DWELL_BEFORE = 3'd3,
    REG_DWELL_MIDDLE = 3'd4,
    REG_DWELL_AFTER  = 3'd5,
    REG_FIRST_LEVEL  = 3'd6,
    REG_SECOND_LEVEL = 3'd7
  } reg_idx_e;

  // sensor flag bit positions
  localparam int unsigned FlagEnter = 0;
  localparam int unsigned FlagHold  = 1;
  localparam int unsigned FlagExit  = 2;

  typedef struct packed {
    logic [PinW-1:0]   enter_pin;
    logic [PinW-1:0]   hold_pin;
    logic [PinW-1:0]   exit_pin;
    logic [DwellW-1:0] dwell_before;
    logic [DwellW-1:0] dwell_middle;
    logic [DwellW-1:0] dwell_after;
    logic [LevelW-1:0] station_first_level;
    logic [LevelW-1:0] station_second_level;
  } cfg_t;

  // first member sits in the top bits, so occupied lands in bit 0
  typedef struct packed {
    phase_e            phase;
    logic [LevelW-1:0] station_level;
    logic [LevelW-1:0] conveyor_level;
    logic              occupied;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

[rtl/czss_cfg.sv]
`timescale 1ns / 1ps
// configuration register file of the station sequencer
// depends on czss_pkg
module czss_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [czss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [czss_pkg::CfgDataW-1:0]     cfg_data_i,
  output czss_pkg::cfg_t                    cfg_o
);

  czss_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (czss_pkg::reg_idx_e'(cfg_idx_i))
        czss_pkg::REG_ENTER_PIN:    cfg_d.enter_pin    = cfg_data_i[czss_pkg::PinW-1:0];
        czss_pkg::REG_HOLD_PIN:     cfg_d.hold_pin     = cfg_data_i[czss_pkg::PinW-1:0];
        czss_pkg::REG_EXIT_PIN:     cfg_d.exit_pin     = cfg_data_i[czss_pkg::PinW-1:0];
        czss_pkg::REG_DWELL_BEFORE: cfg_d.dwell_before = cfg_data_i[czss_pkg::DwellW-1:0];
        czss_pkg::REG_DWELL_MIDDLE: cfg_d.dwell_middle = cfg_data_i[czss_pkg::DwellW-1:0];
        czss_pkg::REG_DWELL_AFTER:  cfg_d.dwell_after  = cfg_data_i[czss_pkg::DwellW-1:0];
        czss_pkg::REG_FIRST_LEVEL:
          cfg_d.station_first_level = cfg_data_i[czss_pkg::LevelW-1:0];
        czss_pkg::REG_SECOND_LEVEL:
          cfg_d.station_second_level = cfg_data_i[czss_pkg::LevelW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_pin            <= 8'd0;
      cfg_q.hold_pin             <= 8'd0;
      cfg_q.exit_pin             <= 8'd0;
      cfg_q.dwell_before         <= 8'd10;
      cfg_q.dwell_middle         <= 8'd25;
      cfg_q.dwell_after          <= 8'd10;
      cfg_q.station_first_level  <= 12'd100;
      cfg_q.station_second_level <= 12'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/czss_core.sv]
`timescale 1ns / 1ps
// zone phase machine, sensor flags, dwell counter and drive registers
// depends on czss_pkg
module czss_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           is_event_i,
  input  logic [czss_pkg::PinW-1:0]      pin_i,
  input  logic                           level_i,
  input  logic                           next_zone_busy_i,
  input  czss_pkg::cfg_t                 cfg_i,
  output czss_pkg::result_t              result_o
);

  czss_pkg::phase_e             phase_q, phase_d;
  czss_pkg::step_e              step_q, step_d;
  logic [2:0]                   flags_q, flags_d;
  logic                         occupied_q, occupied_d;
  logic [czss_pkg::DwellW-1:0]  count_q, count_d;
  logic                         run_q, run_d;
  logic [czss_pkg::LevelW-1:0]  station_q, station_d;

  logic                         is_tick;
  logic [czss_pkg::DwellW-1:0]  limit;
  logic [czss_pkg::DwellW-1:0]  count_inc;
  logic                         dwell_done;

  assign is_tick = accept_i && !is_event_i;

  // dwell limit for the current operation step; unused code runs the after dwell
  always_comb begin
    case (step_q)
      czss_pkg::STEP_BEFORE: limit = cfg_i.dwell_before;
      czss_pkg::STEP_MIDDLE: limit = cfg_i.dwell_middle;
      default:               limit = cfg_i.dwell_after;
    endcase
  end

  assign count_inc  = count_q + 8'd1;
  assign dwell_done = (count_inc >= limit);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (is_tick) begin
      case (phase_q)
        czss_pkg::PH_WAIT_ENTER:
          if (flags_q[czss_pkg::FlagEnter]) phase_d = czss_pkg::PH_WAIT_HOLD;
        czss_pkg::PH_WAIT_HOLD:
          if (flags_q[czss_pkg::FlagHold]) phase_d = czss_pkg::PH_OPERATION;
        czss_pkg::PH_OPERATION:
          if (dwell_done && step_q != czss_pkg::STEP_BEFORE &&
              step_q != czss_pkg::STEP_MIDDLE) begin
            phase_d = czss_pkg::PH_WAIT_NEXT;
          end
        czss_pkg::PH_WAIT_NEXT:
          if (!next_zone_busy_i) phase_d = czss_pkg::PH_WAIT_EXIT;
        czss_pkg::PH_WAIT_EXIT:
          if (flags_q[czss_pkg::FlagExit]) phase_d = czss_pkg::PH_RESET;
        default: phase_d = czss_pkg::PH_WAIT_ENTER;
      endcase
    end
  end

  // flags, occupancy, dwell and drive updates
  always_comb begin
    flags_d    = flags_q;
    occupied_d = occupied_q;
    step_d     = step_q;
    count_d    = count_q;
    run_d      = run_q;
    station_d  = station_q;
    if (accept_i && is_event_i) begin
      // first matching pin wins
      if (!level_i) begin
        if (pin_i == cfg_i.enter_pin) begin
          flags_d[czss_pkg::FlagEnter] = 1'b1;
        end else if (pin_i == cfg_i.hold_pin) begin
          flags_d[czss_pkg::FlagHold] = 1'b1;
        end else if (pin_i == cfg_i.exit_pin) begin
          flags_d[czss_pkg::FlagExit] = 1'b1;
        end
      end
    end else if (is_tick) begin
      case (phase_q)
        czss_pkg::PH_WAIT_ENTER:
          if (flags_q[czss_pkg::FlagEnter]) begin
            run_d      = 1'b1;
            occupied_d = 1'b1;
          end
        czss_pkg::PH_WAIT_HOLD:
          if (flags_q[czss_pkg::FlagHold]) begin
            run_d   = 1'b0;
            step_d  = czss_pkg::STEP_BEFORE;
            count_d = '0;
          end
        czss_pkg::PH_OPERATION: begin
          count_d = count_inc;
          if (dwell_done) begin
            count_d = '0;
            case (step_q)
              czss_pkg::STEP_BEFORE: begin
                station_d = cfg_i.station_first_level;
                step_d    = czss_pkg::STEP_MIDDLE;
              end
              czss_pkg::STEP_MIDDLE: begin
                station_d = cfg_i.station_second_level;
                step_d    = czss_pkg::STEP_AFTER;
              end
              default: step_d = czss_pkg::STEP_BEFORE;
            endcase
          end
        end
        czss_pkg::PH_WAIT_NEXT:
          if (!next_zone_busy_i) run_d = 1'b1;
        czss_pkg::PH_WAIT_EXIT:
          if (flags_q[czss_pkg::FlagExit]) run_d = 1'b0;
        default: begin
          flags_d    = '0;
          occupied_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= czss_pkg::PH_RESET;
      step_q     <= czss_pkg::STEP_BEFORE;
      flags_q    <= '0;
      occupied_q <= 1'b1;
      count_q    <= '0;
      run_q      <= 1'b0;
      station_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      step_q     <= step_d;
      flags_q    <= flags_d;
      occupied_q <= occupied_d;
      count_q    <= count_d;
      run_q      <= run_d;
      station_q  <= station_d;
    end
  end

  // result reports the state after this item's update
  always_comb begin
    result_o.phase          = phase_d;
    result_o.station_level  = station_d;
    result_o.conveyor_level = run_d ? czss_pkg::RunLevel : '0;
    result_o.occupied       = occupied_d;
  end

endmodule

[rtl/czss_obuf.sv]
`timescale 1ns / 1ps
// two-entry output buffer: result register plus skid register
// depends on czss_pkg
module czss_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  czss_pkg::result_t   data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                take_i,
  output czss_pkg::result_t   data_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  czss_pkg::result_t out_q, out_d;
  czss_pkg::result_t skid_q, skid_d;
  logic              drain;

  assign ready_o = !skid_valid_q;
  assign drain   = out_valid_q && take_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no push possible while the skid holds a result
      if (drain) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || drain) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

[rtl/conveyor_zone_station_sequencer.sv]
`timescale 1ns / 1ps
// top level of the conveyor zone station sequencer
// depends on czss_pkg, czss_cfg, czss_core, czss_obuf
//
// channel      direction  width  contents
// s_axis       in         16+1   tick or pin event (tuser: operation)
// m_axis       out        32     occupancy, drive levels, phase
// cfg          in         3+12   register index and write data
//
// one item per cycle while s_axis_tready is high; its result appears in the
// output register on the next cycle unless the output stalls; the state update
// and result are combinational between the core registers and the output register
// a stalled output parks one result in the skid register and drops s_axis_tready
// for as long as the skid is full
// reset clears the phase machine to the reset phase with the zone marked occupied
module conveyor_zone_station_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] pin, [8] level, [9] next_zone_busy, [15:10] zero
  input  logic [czss_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] occupied, [12:1] conveyor_level, [24:13] station_level, [27:25] phase,
  // [31:28] zero
  output logic [czss_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [czss_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [czss_pkg::CfgDataW-1:0]   cfg_data_i
);

  czss_pkg::cfg_t    cfg;
  czss_pkg::result_t result;
  czss_pkg::result_t out_result;
  logic              in_ready;
  logic              in_xfer;

  assign s_axis_tready = in_ready;
  assign in_xfer       = s_axis_tvalid && in_ready;

  czss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  czss_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_xfer),
    .is_event_i       (s_axis_tuser),
    .pin_i            (s_axis_tdata[7:0]),
    .level_i          (s_axis_tdata[8]),
    .next_zone_busy_i (s_axis_tdata[9]),
    .cfg_i            (cfg),
    .result_o         (result)
  );

  czss_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .data_i  (result),
    .ready_o (in_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .data_o  (out_result)
  );

  assign m_axis_tdata = {{(czss_pkg::OutDataW - czss_pkg::ResultW){1'b0}}, out_result};

endmodule

[rtl/czss_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the conveyor zone station sequencer, bound to the top
// depends on czss_pkg and conveyor_zone_station_sequencer_macros.svh
`include "conveyor_zone_station_sequencer_macros.svh"

module czss_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata
);

  logic                         in_xfer;
  logic                         out_stall;
  logic                         out_occupied;
  logic [czss_pkg::LevelW-1:0]  out_conveyor;
  logic                         out_running;
  czss_pkg::phase_e             out_phase;
  logic                         out_hold_wait;
  logic                         out_operation;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_occupied  = m_axis_tdata[0];
  assign out_conveyor  = m_axis_tdata[12:1];
  assign out_running   = (out_conveyor == czss_pkg::RunLevel);
  assign out_phase     = czss_pkg::phase_e'(m_axis_tdata[27:25]);
  assign out_hold_wait = m_axis_tvalid && (out_phase == czss_pkg::PH_WAIT_HOLD);
  assign out_operation = m_axis_tvalid && (out_phase == czss_pkg::PH_OPERATION);

  // a stalled result holds
  `CZSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // a transfer into an empty output shows a result next cycle
  `CZSS_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_xfer && !m_axis_tvalid, m_axis_tvalid)

  // conveyor drive is either stopped or fully on
  `CZSS_ASSERT_NOW(a_conv_level, clk_i, rst_ni, m_axis_tvalid, out_conveyor == '0 || out_running)

  // waiting for hold: zone occupied and conveyor running
  `CZSS_ASSERT_NOW(a_hold_wait, clk_i, rst_ni, out_hold_wait, out_occupied && out_running)

  // station operation runs with the conveyor stopped
  `CZSS_ASSERT_NOW(a_op_stopped, clk_i, rst_ni, out_operation, out_conveyor == '0)

endmodule

bind conveyor_zone_station_sequencer czss_checker u_czss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_conveyor_zone_station_sequencer.sv]
`timescale 1ns / 1ps
// self-checking testbench for conveyor_zone_station_sequencer: stream stimulus,
// a scoreboard class that predicts and checks every result transfer
// depends on czss_pkg and the rtl top level only
import czss_pkg::*;

class zone_sequence_scoreboard;
  cfg_t              cfg;
  phase_e            phase;
  logic [2:0]        flags;
  logic              occupied;
  step_e             step;
  logic [DwellW-1:0] dwell;
  logic [LevelW-1:0] conveyor;
  logic [LevelW-1:0] station;
  result_t           pending_status_q[$];
  int unsigned       errors;

  function new();
    cfg.enter_pin            = '0;
    cfg.hold_pin             = '0;
    cfg.exit_pin             = '0;
    cfg.dwell_before         = 8'd10;
    cfg.dwell_middle         = 8'd25;
    cfg.dwell_after          = 8'd10;
    cfg.station_first_level  = 12'd100;
    cfg.station_second_level = 12'd200;
    phase    = PH_RESET;
    flags    = '0;
    occupied = 1'b1;
    step     = STEP_BEFORE;
    dwell    = '0;
    conveyor = '0;
    station  = '0;
    errors   = 0;
  endfunction

  function void write_reg(reg_idx_e idx, logic [CfgDataW-1:0] value);
    case (idx)
      REG_ENTER_PIN:    cfg.enter_pin            = value[PinW-1:0];
      REG_HOLD_PIN:     cfg.hold_pin             = value[PinW-1:0];
      REG_EXIT_PIN:     cfg.exit_pin             = value[PinW-1:0];
      REG_DWELL_BEFORE: cfg.dwell_before         = value[DwellW-1:0];
      REG_DWELL_MIDDLE: cfg.dwell_middle         = value[DwellW-1:0];
      REG_DWELL_AFTER:  cfg.dwell_after          = value[DwellW-1:0];
      REG_FIRST_LEVEL:  cfg.station_first_level  = value[LevelW-1:0];
      default:          cfg.station_second_level = value[LevelW-1:0];
    endcase
  endfunction

  function void advance_tick(logic busy);
    logic [DwellW-1:0] limit;
    case (phase)
      PH_WAIT_ENTER: begin
        if (flags[FlagEnter]) begin
          conveyor = RunLevel;
          occupied = 1'b1;
          phase    = PH_WAIT_HOLD;
        end
      end
      PH_WAIT_HOLD: begin
        if (flags[FlagHold]) begin
          conveyor = '0;
          step     = STEP_BEFORE;
          dwell    = '0;
          phase    = PH_OPERATION;
        end
      end
      PH_OPERATION: begin
        case (step)
          STEP_BEFORE: limit = cfg.dwell_before;
          STEP_MIDDLE: limit = cfg.dwell_middle;
          default:     limit = cfg.dwell_after;
        endcase
        dwell = dwell + 8'd1;
        // a zero dwell behaves like one tick
        if (dwell >= limit) begin
          dwell = '0;
          case (step)
            STEP_BEFORE: begin
              station = cfg.station_first_level;
              step    = STEP_MIDDLE;
            end
            STEP_MIDDLE: begin
              station = cfg.station_second_level;
              step    = STEP_AFTER;
            end
            default: begin
              step  = STEP_BEFORE;
              phase = PH_WAIT_NEXT;
            end
          endcase
        end
      end
      PH_WAIT_NEXT: begin
        if (!busy) begin
          conveyor = RunLevel;
          phase    = PH_WAIT_EXIT;
        end
      end
      PH_WAIT_EXIT: begin
        if (flags[FlagExit]) begin
          conveyor = '0;
          phase    = PH_RESET;
        end
      end
      default: begin
        flags    = '0;
        occupied = 1'b0;
        phase    = PH_WAIT_ENTER;
      end
    endcase
  endfunction

  function void note_transfer(logic is_event, logic [PinW-1:0] pin, logic level, logic busy);
    result_t status;
    if (is_event) begin
      // first matching pin wins: enter, then hold, then exit
      if (!level) begin
        if (pin == cfg.enter_pin)     flags[FlagEnter] = 1'b1;
        else if (pin == cfg.hold_pin) flags[FlagHold]  = 1'b1;
        else if (pin == cfg.exit_pin) flags[FlagExit]  = 1'b1;
      end
    end else begin
      advance_tick(busy);
    end
    status.occupied       = occupied;
    status.conveyor_level = conveyor;
    status.station_level  = station;
    status.phase          = phase;
    pending_status_q.push_back(status);
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  task check_result(logic [OutDataW-1:0] data);
    result_t got;
    result_t want;
    got = result_t'(data[ResultW-1:0]);
    if (pending_status_q.size() == 0) begin
      report("result with nothing pending", data, 0);
      return;
    end
    want = pending_status_q.pop_front();
    if (got.occupied !== want.occupied)
      report("occupied", got.occupied, want.occupied);
    if (got.conveyor_level !== want.conveyor_level)
      report("conveyor_level", got.conveyor_level, want.conveyor_level);
    if (got.station_level !== want.station_level)
      report("station_level", got.station_level, want.station_level);
    if (got.phase !== want.phase)
      report("phase", got.phase, want.phase);
    if (data[OutDataW-1:ResultW] !== '0)
      report("tdata padding", data[OutDataW-1:ResultW], 0);
  endtask
endclass

module tb_conveyor_zone_station_sequencer;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 120;
  localparam logic        OpTick        = 1'b0;
  localparam logic        OpEvent       = 1'b1;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  zone_sequence_scoreboard sb;
  cfg_t        cur_cfg;
  int unsigned burst_left;
  int unsigned gap_max;
  bit          hold_off_req;
  int unsigned cycle_count;

  conveyor_zone_station_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // results are checked before the same-edge input is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_transfer(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], s_axis_tdata[9]);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("conveyor_zone_station_sequencer verification failed");
    $finish;
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned beat;
    mode      = 0;
    mode_left = 0;
    beat      = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(40, 120);
        end
        mode_left--;
        beat++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (beat % 4) == 0;
          default: m_axis_tready <= (beat % 12) >= 8;
        endcase
      end
    end
  end

  task automatic offer(logic op, logic [PinW-1:0] pin, logic level, logic busy);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW-10){1'b0}}, busy, level, pin};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // step past the current edge first so the last transfer is already noted
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // 8-bit registers get random upper bits that must be ignored
  task automatic apply_config(cfg_t c);
    logic [CfgDataW-1:0] value;
    reg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_e'(i);
      value = {4'($urandom_range(0, 15)), 8'h00};
      case (idx)
        REG_ENTER_PIN:    value[7:0] = c.enter_pin;
        REG_HOLD_PIN:     value[7:0] = c.hold_pin;
        REG_EXIT_PIN:     value[7:0] = c.exit_pin;
        REG_DWELL_BEFORE: value[7:0] = c.dwell_before;
        REG_DWELL_MIDDLE: value[7:0] = c.dwell_middle;
        REG_DWELL_AFTER:  value[7:0] = c.dwell_after;
        REG_FIRST_LEVEL:  value = c.station_first_level;
        default:          value = c.station_second_level;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= value;
      sb.write_reg(idx, value);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    @(posedge clk_i);
  endtask

  function automatic cfg_t random_cfg(int unsigned dwell_max, bit allow_clash);
    cfg_t c;
    c.enter_pin = 8'($urandom_range(0, 255));
    c.hold_pin  = 8'($urandom_range(0, 255));
    c.exit_pin  = 8'($urandom_range(0, 255));
    if (!allow_clash) begin
      while (c.hold_pin == c.enter_pin) c.hold_pin = 8'($urandom_range(0, 255));
      while (c.exit_pin == c.enter_pin || c.exit_pin == c.hold_pin)
        c.exit_pin = 8'($urandom_range(0, 255));
    end
    c.dwell_before         = 8'($urandom_range(0, dwell_max));
    c.dwell_middle         = 8'($urandom_range(0, dwell_max));
    c.dwell_after          = 8'($urandom_range(0, dwell_max));
    c.station_first_level  = 12'($urandom_range(0, 4095));
    c.station_second_level = 12'($urandom_range(0, 4095));
    return c;
  endfunction

  // mostly ticks and the sensor the zone waits for, the rest noise
  task automatic random_item(int unsigned tick_pct, output bit counted);
    int unsigned r;
    logic [PinW-1:0] pin;
    logic level;
    logic busy;
    r     = $urandom_range(0, 99);
    pin   = 8'($urandom_range(0, 255));
    level = 1'($urandom_range(0, 1));
    busy  = ($urandom_range(0, 3) == 0);
    counted = 1'b0;
    if (r < tick_pct) begin
      offer(OpTick, pin, level, busy);
      counted = 1'b1;
    end else if (r < tick_pct + (100 - tick_pct) * 2 / 3) begin
      case (sb.phase)
        PH_RESET, PH_WAIT_ENTER: pin = cur_cfg.enter_pin;
        PH_WAIT_HOLD:            pin = cur_cfg.hold_pin;
        PH_WAIT_EXIT:            pin = cur_cfg.exit_pin;
        default: begin
          case ($urandom_range(0, 2))
            0:       pin = cur_cfg.enter_pin;
            1:       pin = cur_cfg.hold_pin;
            default: pin = cur_cfg.exit_pin;
          endcase
        end
      endcase
      level = ($urandom_range(0, 9) == 0);
      offer(OpEvent, pin, level, busy);
      counted = !level;
    end else begin
      offer(OpEvent, pin, level, busy);
    end
  endtask

  task automatic run_random(int unsigned target, int unsigned tick_pct, bit pause_midway);
    int unsigned done;
    bit counted;
    done = 0;
    while (done < target) begin
      random_item(tick_pct, counted);
      if (counted) done++;
      if (pause_midway && done == target / 2) begin
        wait_idle();
        pause_midway = 1'b0;
      end
    end
  endtask

  initial begin : main
    cfg_t c;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    hold_off_req  = 1'b0;
    burst_left    = 0;
    gap_max       = 3;
    cur_cfg       = sb.cfg;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // hold and exit share a pin, so hold wins; shortest and zero dwells
    c = '{enter_pin: 8'h00, hold_pin: 8'hFF, exit_pin: 8'hFF,
          dwell_before: 8'd0, dwell_middle: 8'd1, dwell_after: 8'd2,
          station_first_level: 12'hFFF, station_second_level: 12'h000};
    apply_config(c);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpEvent, 8'h00, 1'b1, 1'b0);
    offer(OpTick,  8'hFF, 1'b1, 1'b1);
    offer(OpEvent, 8'hFF, 1'b0, 1'b0);
    offer(OpEvent, 8'h00, 1'b0, 1'b1);
    offer(OpTick,  8'h00, 1'b0, 1'b1);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b1);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpEvent, 8'd200, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    wait_idle();

    // enter and hold share a pin, so enter wins; exit closes the previous run
    c = '{enter_pin: 8'h3C, hold_pin: 8'h3C, exit_pin: 8'h81,
          dwell_before: 8'd1, dwell_middle: 8'd1, dwell_after: 8'd1,
          station_first_level: 12'h555, station_second_level: 12'hAAA};
    apply_config(c);
    offer(OpEvent, 8'h81, 1'b0, 1'b1);
    offer(OpTick,  8'h81, 1'b1, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpEvent, 8'h3C, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    offer(OpEvent, 8'h3C, 1'b1, 1'b0);
    offer(OpTick,  8'h00, 1'b0, 1'b0);
    wait_idle();

    for (int k = 0; k < 6; k++) begin
      c = random_cfg(5, k == 5);
      gap_max = $urandom_range(0, 8);
      if (k == 0) begin
        c.dwell_before         = 8'd10;
        c.dwell_middle         = 8'd25;
        c.dwell_after          = 8'd10;
        c.station_first_level  = 12'd100;
        c.station_second_level = 12'd200;
        gap_max = 5;
      end else if (k == 1) begin
        c = '{enter_pin: 8'hFF, hold_pin: 8'h00, exit_pin: 8'h01,
              dwell_before: 8'd255, dwell_middle: 8'd0, dwell_after: 8'd1,
              station_first_level: 12'h000, station_second_level: 12'hFFF};
      end
      apply_config(c);
      if (k == 2) begin
        // back-to-back offers against a long receiver hold-off
        gap_max = 0;
        hold_off_req = 1'b1;
      end
      if (k == 1) run_random(300, 92, 1'b0);
      else        run_random(130, 55, k == 3);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending_status_q.size() != 0)
      sb.report("results never arrived", sb.pending_status_q.size(), 0);
    if (sb.errors == 0) begin
      $display("conveyor_zone_station_sequencer verification clean");
    end else begin
      $display("conveyor_zone_station_sequencer verification failed");
    end
    $finish;
  end

endmodule
